[rtl/integer_matrix_multiply_accumulate_macros.svh]
// Assertion macros for the matrix multiply-accumulate block
`ifndef INTEGER_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define IMMA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define IMMA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/imma_pkg.sv]
// ----------------------------------------------------------------------------
// imma_pkg
// Types, commands and constants shared by the matrix multiply-accumulate files.
// ----------------------------------------------------------------------------
package imma_pkg;

    localparam int MaxSize   = 16;
    localparam int IdxW      = $clog2(MaxSize);
    localparam int AddrW     = 2 * IdxW;
    localparam int Depth     = MaxSize * MaxSize;
    localparam int SizeW     = 5;
    localparam int DataW     = 32;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW = $clog2(QueueDepth);
    localparam int ClearCycles = Depth;

    typedef enum logic [1:0] {
        CMD_LOAD_A   = 2'd0,
        CMD_LOAD_B   = 2'd1,
        CMD_LOAD_OUT = 2'd2,
        CMD_COMPUTE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [3:0]        row_index;
        logic [3:0]        col_index;
        logic signed [31:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        out_row;
        logic [3:0]        out_col;
        logic signed [31:0] product_value;
        logic              last_of_row;
    } out_item_t;

    // Classified work passed from the front end to the engine
    typedef struct packed {
        cmd_t              cmd;
        logic [IdxW-1:0]   row;
        logic [IdxW-1:0]   col;
        logic [DataW-1:0]  value;
    } job_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ACC,
        ST_EMIT
    } eng_state_t;

endpackage

[rtl/imma_front.sv]
// ----------------------------------------------------------------------------
// imma_front
// Accepts command beats, drops those that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module imma_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  imma_pkg::in_item_t    s_data,
    input  logic [4:0]            size_in_use,
    output logic                  job_valid,
    input  logic                  job_ready,
    output imma_pkg::job_t        job_data
);

    imma_pkg::job_t                    queue_reg [imma_pkg::QueueDepth];
    logic [imma_pkg::QueuePtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [imma_pkg::QueuePtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [imma_pkg::QueuePtrW:0]      count_reg, count_next;
    logic                              push, pop, keep;
    imma_pkg::job_t                    job_in;

    // Classify: computes of rows beyond the size in use do nothing
    always_comb begin
        job_in.cmd   = imma_pkg::cmd_t'(s_data.command);
        job_in.row   = s_data.row_index[imma_pkg::IdxW-1:0];
        job_in.col   = s_data.col_index[imma_pkg::IdxW-1:0];
        job_in.value = s_data.element_value;
        if (job_in.cmd == imma_pkg::CMD_COMPUTE) begin
            keep = ({1'b0, s_data.row_index} < size_in_use);
        end else begin
            keep = 1'b1;
        end
    end

    assign s_ready   = (count_reg != (imma_pkg::QueuePtrW+1)'(imma_pkg::QueueDepth));
    assign push      = s_valid && s_ready && keep;
    assign job_valid = (count_reg != '0);
    assign pop       = job_valid && job_ready;
    assign job_data  = queue_reg[rd_ptr_reg];

    // Advance pointers
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (imma_pkg::QueuePtrW+1)'(push)
                      - (imma_pkg::QueuePtrW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued jobs
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[rtl/imma_engine.sv]
// ----------------------------------------------------------------------------
// imma_engine
// Performs loads into the three stores and row computes with one MAC unit.
// ----------------------------------------------------------------------------
module imma_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  imma_pkg::job_t        job_data,
    input  logic [4:0]            size_in_use,
    output logic                  m_valid,
    input  logic                  m_ready,
    output imma_pkg::out_item_t   m_data,
    output logic                  clearing
);

    localparam int IW = imma_pkg::IdxW;
    localparam int AW = imma_pkg::AddrW;

    logic [31:0] a_mem [imma_pkg::Depth];
    logic [31:0] b_mem [imma_pkg::Depth];
    logic [31:0] p_mem [imma_pkg::Depth];

    imma_pkg::eng_state_t state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [IW-1:0]  row_reg, row_next;
    logic [IW:0]    col_reg, col_next;
    logic [IW:0]    k_reg, k_next;
    logic [31:0]    a_q_reg, b_q_reg, p_q_reg;
    logic [31:0]    prod_reg, sum_reg, sum_next;
    logic           prod_vld_reg, prod_vld_next;
    logic           rd_vld_reg, rd_vld_next;
    logic           out_vld_reg, out_vld_next;
    imma_pkg::out_item_t out_reg;
    logic           take, issue, last_k, last_col, out_free;
    logic [AW-1:0]  a_rd_addr, b_rd_addr, p_addr;
    logic [AW-1:0]  ld_addr;
    logic [31:0]    acc_val;

    assign ld_addr   = {job_data.row, job_data.col};
    assign a_rd_addr = {row_reg, k_reg[IW-1:0]};
    assign b_rd_addr = {k_reg[IW-1:0], col_reg[IW-1:0]};
    assign p_addr    = {row_reg, col_reg[IW-1:0]};
    assign last_k    = (k_reg == size_in_use - 5'd1);
    assign last_col  = (col_reg == size_in_use - 5'd1);
    assign out_free  = !out_vld_reg || m_ready;
    assign acc_val   = p_q_reg + sum_reg;
    assign clearing  = (state_reg == imma_pkg::ST_CLEAR);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imma_pkg::ST_CLEAR: begin
                if (clr_reg == '1) state_next = imma_pkg::ST_IDLE;
            end
            imma_pkg::ST_IDLE: begin
                if (job_valid && job_data.cmd == imma_pkg::CMD_COMPUTE)
                    state_next = imma_pkg::ST_MAC;
            end
            imma_pkg::ST_MAC: begin
                if (last_k) state_next = imma_pkg::ST_DRAIN;
            end
            imma_pkg::ST_DRAIN: begin
                if (!rd_vld_reg && !prod_vld_reg) state_next = imma_pkg::ST_ACC;
            end
            imma_pkg::ST_ACC: begin
                if (out_free) state_next = imma_pkg::ST_EMIT;
            end
            imma_pkg::ST_EMIT: begin
                state_next = last_col ? imma_pkg::ST_IDLE : imma_pkg::ST_MAC;
            end
            default: state_next = imma_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        job_ready     = 1'b0;
        take          = 1'b0;
        issue         = 1'b0;
        clr_next      = clr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        rd_vld_next   = 1'b0;
        prod_vld_next = rd_vld_reg;
        sum_next      = sum_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        if (prod_vld_reg) sum_next = sum_reg + prod_reg;
        case (state_reg)
            imma_pkg::ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
            end
            imma_pkg::ST_IDLE: begin
                job_ready = 1'b1;
                take      = job_valid;
                if (job_valid && job_data.cmd == imma_pkg::CMD_COMPUTE) begin
                    row_next = job_data.row;
                    col_next = '0;
                    k_next   = '0;
                    sum_next = '0;
                end
            end
            imma_pkg::ST_MAC: begin
                issue       = 1'b1;
                rd_vld_next = 1'b1;
                k_next      = k_reg + 1'b1;
            end
            imma_pkg::ST_ACC: begin
                if (out_free) out_vld_next = 1'b1;
            end
            imma_pkg::ST_EMIT: begin
                col_next = col_reg + 1'b1;
                k_next   = '0;
                sum_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= imma_pkg::ST_CLEAR;
            clr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= prod_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        k_reg    <= k_next;
        sum_reg  <= sum_next;
        prod_reg <= a_q_reg * b_q_reg;
    end

    // A and B stores: load writes, registered MAC reads
    always_ff @(posedge aclk) begin
        if (take && job_data.cmd == imma_pkg::CMD_LOAD_A) a_mem[ld_addr] <= job_data.value;
        if (issue) a_q_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (take && job_data.cmd == imma_pkg::CMD_LOAD_B) b_mem[ld_addr] <= job_data.value;
        if (issue) b_q_reg <= b_mem[b_rd_addr];
    end

    // Product store: clear pass, loads, read ahead and accumulate write
    always_ff @(posedge aclk) begin
        if (state_reg == imma_pkg::ST_CLEAR) begin
            p_mem[clr_reg] <= '0;
        end else if (take && job_data.cmd == imma_pkg::CMD_LOAD_OUT) begin
            p_mem[ld_addr] <= job_data.value;
        end else if (state_reg == imma_pkg::ST_ACC && out_free) begin
            p_mem[p_addr] <= acc_val;
        end
        p_q_reg <= p_mem[p_addr];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (state_reg == imma_pkg::ST_ACC && out_free) begin
            out_reg.out_row       <= 4'(row_reg);
            out_reg.out_col       <= 4'(col_reg);
            out_reg.product_value <= acc_val;
            out_reg.last_of_row   <= last_col;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

[rtl/integer_matrix_multiply_accumulate.sv]
// ----------------------------------------------------------------------------
// integer_matrix_multiply_accumulate
// Square 32-bit integer multiply-accumulate, out += A * B, one row per command.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries command beats: load an element of A, B or the product
//   store, or compute one row. Loads give no result beat. A compute of row r
//   gives matrix_size beats on the m_ channel, last_of_row set on the final.
//   cfg_ channel writes matrix_size (0 acts as 1, above 16 acts as 16); write
//   it only while the block is idle.
//   A front end queues up to four beats; the engine takes loads only when idle.
//   A compute runs on one multiplier and one read port per store, one term
//   per cycle, plus a pipeline drain and an accumulate and emit step per
//   column.
//   After reset the product store is cleared, one entry per cycle, all 256
//   entries; s_ready stays low meanwhile, cfg writes are taken.
//   If the receiver stalls, the engine holds its next result and the queue
//   fills, then s_ready drops.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_accumulate_macros.svh"
module integer_matrix_multiply_accumulate (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  imma_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output imma_pkg::out_item_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [4:0]            cfg_data
);

    logic [4:0]     matrix_size_reg;
    logic [4:0]     size_in_use;
    logic           job_valid, job_ready, clearing, front_ready;
    imma_pkg::job_t job_data;

    assign cfg_ready = 1'b1;

    // Hold the size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= 5'd16;
        end else if (cfg_valid) begin
            matrix_size_reg <= cfg_data;
        end
    end

    // Clamp to the supported range
    always_comb begin
        if (matrix_size_reg == '0) size_in_use = 5'd1;
        else if (matrix_size_reg > 5'(imma_pkg::MaxSize)) size_in_use = 5'(imma_pkg::MaxSize);
        else size_in_use = matrix_size_reg;
    end

    assign s_ready = front_ready && !clearing;

    imma_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid && !clearing),
        .s_ready     (front_ready),
        .s_data      (s_data),
        .size_in_use (size_in_use),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_data    (job_data)
    );

    imma_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_data    (job_data),
        .size_in_use (size_in_use),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .clearing    (clearing)
    );

    `IMMA_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, clearing, !s_ready, "beat accepted during clear")
    `IMMA_ASSERT_IMP(a_no_out_clear, aclk, aresetn, clearing, !m_valid, "result during clear")
    `IMMA_ASSERT_IMP(a_col_in_size, aclk, aresetn, m_valid, ({1'b0, m_data.out_col} < size_in_use), "column beyond size")
    `IMMA_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped under stall")

endmodule
